// File: rtl/sent_slow_message_mailbox_macros.svh
// Assertion macros shared by the mailbox checks.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SENT_SLOW_MESSAGE_MAILBOX_MACROS_SVH
`define SENT_SLOW_MESSAGE_MAILBOX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSMM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mailbox check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mailbox check failed");

`endif

// File: rtl/ssmm_pkg.sv
`default_nettype none

package ssmm_pkg;

  localparam int SLOT_COUNT = 22;
  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
  localparam int ID_W = 8;
  localparam int DATA_W = 16;
  localparam int TIME_PORT_W = 32;
  localparam int DEFAULT_TIME_WIDTH = 32;

  localparam logic [ID_W-1:0] ID_NIBBLE = 8'h06;
  localparam logic [ID_W-1:0] ID_BYTE = 8'h24;
  localparam logic [ID_W-1:0] ID_GROUP_LO = 8'h90;
  localparam logic [ID_W-1:0] ID_GROUP_HI = 8'h97;
  localparam logic [DATA_W-1:0] MASK_NIBBLE = 16'h000F;
  localparam logic [DATA_W-1:0] MASK_BYTE = 16'h00FF;
  localparam int GROUP_BASE_SLOT = 14;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_EMPTY = 1'b1
  } status_t;

  typedef struct packed {
    logic store_en;
    logic read_en;
  } ctl_cmd_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] idx;
  } slot_hit_t;

  function automatic slot_hit_t slot_lookup(input logic [ID_W-1:0] id);
    slot_hit_t        r;
    logic [ID_W-1:0]  ofs;
    r.hit = 1'b1;
    r.idx = '0;
    ofs = id - ID_GROUP_LO;
    unique case (id)
      8'h01: r.idx = SLOT_IDX_W'(0);
      8'h03: r.idx = SLOT_IDX_W'(1);
      8'h05: r.idx = SLOT_IDX_W'(2);
      ID_NIBBLE: r.idx = SLOT_IDX_W'(3);
      8'h07: r.idx = SLOT_IDX_W'(4);
      8'h08: r.idx = SLOT_IDX_W'(5);
      8'h09: r.idx = SLOT_IDX_W'(6);
      8'h0A: r.idx = SLOT_IDX_W'(7);
      8'h23: r.idx = SLOT_IDX_W'(8);
      ID_BYTE: r.idx = SLOT_IDX_W'(9);
      8'h29: r.idx = SLOT_IDX_W'(10);
      8'h2A: r.idx = SLOT_IDX_W'(11);
      8'h2B: r.idx = SLOT_IDX_W'(12);
      8'h2C: r.idx = SLOT_IDX_W'(13);
      default: begin
        if (id >= ID_GROUP_LO && id <= ID_GROUP_HI) begin
          r.idx = SLOT_IDX_W'(GROUP_BASE_SLOT) + ofs[SLOT_IDX_W-1:0];
        end else begin
          r.hit = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] mask_data(input logic [ID_W-1:0] id,
                                                  input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] r;
    r = data;
    if (id == ID_NIBBLE) begin
      r = data & MASK_NIBBLE;
    end else if (id == ID_BYTE) begin
      r = data & MASK_BYTE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ssmm_ctrl.sv
`default_nettype none

module ssmm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              command,
  input  wire logic              out_stall,
  output logic                   in_stall,
  output logic                   out_valid,
  output ssmm_pkg::ctl_cmd_t     ctl
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state == ST_FULL) && out_stall;
  assign accept = in_valid && !in_stall;
  assign ctl.store_en = accept && (command == ssmm_pkg::CMD_STORE);
  assign ctl.read_en = accept && (command == ssmm_pkg::CMD_READ);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EMPTY: begin
        if (ctl.read_en) begin
          state_next = ST_FULL;
        end
      end
      ST_FULL: begin
        if (ctl.read_en) begin
          state_next = ST_FULL;
        end else if (!out_stall) begin
          state_next = ST_EMPTY;
        end
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= (state_next == ST_FULL);
    end
  end

endmodule

`default_nettype wire

// File: rtl/ssmm_datapath.sv
`default_nettype none

module ssmm_datapath #(
  parameter int TIME_WIDTH = ssmm_pkg::DEFAULT_TIME_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire ssmm_pkg::ctl_cmd_t               ctl,
  input  wire logic [ssmm_pkg::ID_W-1:0]        msg_id,
  input  wire logic [ssmm_pkg::DATA_W-1:0]      msg_data,
  input  wire logic [ssmm_pkg::TIME_PORT_W-1:0] rx_time,
  output logic                                  status,
  output logic [ssmm_pkg::DATA_W-1:0]           read_data,
  output logic [ssmm_pkg::TIME_PORT_W-1:0]      read_time
);

  logic [ssmm_pkg::DATA_W-1:0]      slot_data [ssmm_pkg::SLOT_COUNT];
  logic [TIME_WIDTH-1:0]            slot_time [ssmm_pkg::SLOT_COUNT];
  logic [ssmm_pkg::SLOT_COUNT-1:0]  slot_valid;
  ssmm_pkg::slot_hit_t              hit;
  logic [TIME_WIDTH-1:0]            time_in;
  logic [TIME_WIDTH-1:0]            time_sel;
  logic [ssmm_pkg::TIME_PORT_W-1:0] time_out;

  assign hit = ssmm_pkg::slot_lookup(msg_id);
  assign time_sel = slot_time[hit.idx];

  if (TIME_WIDTH <= ssmm_pkg::TIME_PORT_W) begin : g_narrow
    assign time_in = rx_time[TIME_WIDTH-1:0];
    assign time_out = ssmm_pkg::TIME_PORT_W'(time_sel);
  end else begin : g_wide
    assign time_in = TIME_WIDTH'(rx_time);
    assign time_out = time_sel[ssmm_pkg::TIME_PORT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.store_en && hit.hit) begin
      slot_data[hit.idx] <= ssmm_pkg::mask_data(msg_id, msg_data);
      slot_time[hit.idx] <= time_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (hit.hit) begin
      if (ctl.store_en) begin
        slot_valid[hit.idx] <= 1'b1;
      end else if (ctl.read_en) begin
        slot_valid[hit.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.read_en) begin
      if (hit.hit && slot_valid[hit.idx]) begin
        status <= ssmm_pkg::STATUS_OK;
        read_data <= slot_data[hit.idx];
        read_time <= time_out;
      end else begin
        status <= ssmm_pkg::STATUS_EMPTY;
        read_data <= '0;
        read_time <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sent_slow_message_mailbox.sv
// Mailbox for received SENT slow-channel messages, one slot per known message ID.
// Input channel: in_valid/in_stall with command, msg_id, msg_data and rx_time.
// A store request writes the masked data and the timestamp into the slot of
// its ID and marks the slot full; it produces no response. A store with an
// unknown ID is dropped.
// A read request produces one response on out_valid/out_stall with status,
// read_data and read_time, and empties the slot. Unknown IDs and empty slots
// answer with status 1 and zero data and time.
// A read response is valid in the cycle after the request is accepted.
// Throughput: one request per cycle unless a pending response is stalled; the
// response register lets the next request in while the receiver takes the
// current response. When the receiver stalls a pending response, in_stall
// rises and the response holds until it is taken.
// Reset empties every slot at once and drops any pending response.
`default_nettype none

module sent_slow_message_mailbox #(
  parameter int TIME_WIDTH = ssmm_pkg::DEFAULT_TIME_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             command,
  input  wire logic [ssmm_pkg::ID_W-1:0]        msg_id,
  input  wire logic [ssmm_pkg::DATA_W-1:0]      msg_data,
  input  wire logic [ssmm_pkg::TIME_PORT_W-1:0] rx_time,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  status,
  output logic [ssmm_pkg::DATA_W-1:0]           read_data,
  output logic [ssmm_pkg::TIME_PORT_W-1:0]      read_time
);

  ssmm_pkg::ctl_cmd_t ctl;

  ssmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  ssmm_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .msg_id    (msg_id),
    .msg_data  (msg_data),
    .rx_time   (rx_time),
    .status    (status),
    .read_data (read_data),
    .read_time (read_time)
  );

endmodule

`default_nettype wire

// File: rtl/ssmm_checker.sv
`default_nettype none
`include "sent_slow_message_mailbox_macros.svh"

module ssmm_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             command,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic                             status,
  input wire logic [ssmm_pkg::DATA_W-1:0]      read_data,
  input wire logic [ssmm_pkg::TIME_PORT_W-1:0] read_time
);

  logic in_accept;
  logic is_read;

  assign in_accept = in_valid && !in_stall;
  assign is_read = (command == ssmm_pkg::CMD_READ);

  `SSMM_ASSERT_NEXT(a_read_gives_response, in_accept && is_read, out_valid)
  `SSMM_ASSERT_NEXT(a_store_no_response,
                    in_accept && !is_read && !(out_valid && out_stall), !out_valid)
  `SSMM_ASSERT_SAME(a_empty_is_zero, out_valid && (status == ssmm_pkg::STATUS_EMPTY),
                    read_data == '0 && read_time == '0)
  `SSMM_ASSERT_NEXT(a_stall_holds, out_valid && out_stall,
                    out_valid && $stable(status) && $stable(read_data) && $stable(read_time))

endmodule

bind sent_slow_message_mailbox ssmm_checker u_ssmm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .command   (command),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .read_data (read_data),
  .read_time (read_time)
);

`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
  import ssmm_pkg::*;

  localparam int HOLD_CYCLES = 80;

  typedef struct {
    status_t           st;
    logic [DATA_W-1:0] data;
    logic [31:0]       stamp;
  } reply_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   command = CMD_STORE;
  logic [ID_W-1:0]        msg_id = '0;
  logic [DATA_W-1:0]      msg_data = '0;
  logic [TIME_PORT_W-1:0] rx_time = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   status;
  logic [DATA_W-1:0]      read_data;
  logic [TIME_PORT_W-1:0] read_time;

  logic [ID_W-1:0] known_ids [SLOT_COUNT] = '{
    8'h01, 8'h03, 8'h05, ID_NIBBLE, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h23, ID_BYTE, 8'h29,
    8'h2A, 8'h2B, 8'h2C, ID_GROUP_LO, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
    ID_GROUP_HI
  };

  logic [DATA_W-1:0] box_data [SLOT_COUNT];
  logic [31:0]       box_time [SLOT_COUNT];
  bit                box_full [SLOT_COUNT];

  reply_t pending_replies [$];
  reply_t head;
  bit     failed = 1'b0;
  bit     idle_on = 1'b0;
  int     hold_asked = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  int     burst_left = 0;

  sent_slow_message_mailbox u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .msg_id    (msg_id),
    .msg_data  (msg_data),
    .rx_time   (rx_time),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .read_data (read_data),
    .read_time (read_time)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int slot_index(input logic [ID_W-1:0] id);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (known_ids[i] == id) begin
        return i;
      end
    end
    return -1;
  endfunction

  task automatic mailbox_apply(input cmd_t cmd, input logic [ID_W-1:0] id,
                               input logic [DATA_W-1:0] data, input logic [31:0] stamp);
    int     s;
    reply_t r;
    s = slot_index(id);
    if (cmd == CMD_STORE) begin
      if (s >= 0) begin
        if (id == ID_NIBBLE) begin
          data = data & MASK_NIBBLE;
        end else if (id == ID_BYTE) begin
          data = data & MASK_BYTE;
        end
        box_data[s] = data;
        box_time[s] = stamp;
        box_full[s] = 1'b1;
      end
    end else begin
      if (s < 0 || !box_full[s]) begin
        r = '{STATUS_EMPTY, 16'h0, 32'h0};
      end else begin
        r = '{STATUS_OK, box_data[s], box_time[s]};
        box_full[s] = 1'b0;
      end
      pending_replies.push_back(r);
    end
  endtask

  task automatic offer_request(input cmd_t cmd, input logic [ID_W-1:0] id,
                               input logic [DATA_W-1:0] data, input logic [31:0] stamp);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    msg_id <= id;
    msg_data <= data;
    rx_time <= stamp;
    do @(posedge clk); while (in_stall);
    mailbox_apply(cmd, id, data, stamp);
  endtask

  task automatic random_request();
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    logic [31:0]       stamp;
    cmd = ($urandom_range(0, 1) == 0) ? CMD_STORE : CMD_READ;
    if ($urandom_range(0, 3) != 0) begin
      id = known_ids[$urandom_range(0, SLOT_COUNT - 1)];
    end else begin
      id = ID_W'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 7))
      0: data = 16'h0000;
      1: data = 16'hFFFF;
      default: data = DATA_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: stamp = 32'h0000_0000;
      1: stamp = 32'hFFFF_FFFF;
      default: stamp = $urandom;
    endcase
    offer_request(cmd, id, data, stamp);
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    offer_request(CMD_STORE, ID_NIBBLE, 16'hFFFF, 32'hFFFF_FFFF);
    offer_request(CMD_STORE, ID_BYTE, 16'hFFFF, 32'h0000_0000);
    offer_request(CMD_STORE, ID_GROUP_HI, 16'h0000, 32'h8000_0001);
    offer_request(CMD_STORE, 8'h01, 16'hFFFF, 32'h1234_5678);
    offer_request(CMD_STORE, 8'h01, 16'h1234, 32'hFFFF_FFFF);
    offer_request(CMD_STORE, 8'h00, 16'hAAAA, 32'h5555_5555);
    offer_request(CMD_STORE, 8'hFF, 16'h5555, 32'hAAAA_AAAA);
    offer_request(CMD_STORE, 8'h98, 16'hFFFF, 32'hFFFF_FFFF);
    offer_request(CMD_READ, ID_NIBBLE, 16'h0000, 32'h0);
    offer_request(CMD_READ, ID_BYTE, 16'hFFFF, 32'hFFFF_FFFF);
    offer_request(CMD_READ, ID_GROUP_HI, 16'h0000, 32'h0);
    offer_request(CMD_READ, 8'h01, 16'h0000, 32'h0);
    offer_request(CMD_READ, 8'h01, 16'h0000, 32'h0);
    offer_request(CMD_READ, 8'h03, 16'h0000, 32'h0);
    offer_request(CMD_READ, 8'h00, 16'h0000, 32'h0);
    offer_request(CMD_READ, 8'hFF, 16'h0000, 32'h0);
    offer_request(CMD_READ, 8'h98, 16'h0000, 32'h0);
    offer_request(CMD_READ, 8'h8F, 16'h0000, 32'h0);
    offer_request(CMD_STORE, ID_GROUP_LO, 16'h8001, 32'h0000_0001);
    offer_request(CMD_READ, ID_GROUP_LO, 16'h0000, 32'h0);
  endtask

  task automatic test_random_traffic(input int count);
    idle_on <= 1'b1;
    repeat (count) random_request();
  endtask

  // The receiver holds off while requests keep coming, so the input side must stall.
  task automatic test_full_stall();
    idle_on <= 1'b0;
    hold_asked <= hold_asked + 1;
    repeat (40) offer_request(CMD_READ, known_ids[$urandom_range(0, SLOT_COUNT - 1)],
                              DATA_W'($urandom), $urandom);
  endtask

  task automatic test_drain_pause(input int count);
    wait_for_replies();
    idle_on <= 1'b1;
    repeat (count) random_request();
  endtask

  task automatic test_steady_stream(input int count);
    idle_on <= 1'b0;
    repeat (count) random_request();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_stall <= 1'b1;
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES - 1;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      burst_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected response: status %0d read_data %h read_time %h",
               status, read_data, read_time);
        failed = 1'b1;
      end else begin
        head = pending_replies.pop_front();
        if (status !== head.st) begin
          $error("status: expected %0d, actual %0d", head.st, status);
          failed = 1'b1;
        end
        if (read_data !== head.data) begin
          $error("read_data: expected %h, actual %h", head.data, read_data);
          failed = 1'b1;
        end
        if (read_time !== head.stamp) begin
          $error("read_time: expected %h, actual %h", head.stamp, read_time);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(600);
    test_full_stall();
    test_drain_pause(250);
    test_steady_stream(150);
    wait_for_replies();
    repeat (5) @(posedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
